// ===== rtl/tiled_slot_occupancy_map_defines.svh =====
// Assertion macros for the occupancy map RTL.
`ifndef TILED_SLOT_OCCUPANCY_MAP_DEFINES_SVH
`define TILED_SLOT_OCCUPANCY_MAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSOM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsom check failed");

// Next-cycle implication, checked outside reset.
`define TSOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsom check failed");

`endif

// ===== rtl/tsom_pkg.sv =====
// Types and constants of the tiled slot occupancy map.
package tsom_pkg;

    localparam int SLOT_W      = 8;
    localparam int OWNER_W     = 8;
    localparam int POS_W       = 4;
    localparam int WALK_W      = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        OP_RESET   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_FIND    = 3'd2,
        OP_MARK    = 3'd3,
        OP_CURSOR  = 3'd4
    } t_op;

    // Walker control from the sequencer.
    typedef struct packed {
        logic             start;
        logic             advance;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_walk_ctl;

    // Walker status back to the sequencer.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] idx;
    } t_walk_sts;

endpackage

// ===== rtl/tsom_ram.sv =====
// Occupancy byte memory: one write port, one registered read port.
module tsom_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tsom_pkg::SLOT_W-1:0]  i_waddr,
    input  logic [tsom_pkg::OWNER_W-1:0] i_wdata,
    input  logic [tsom_pkg::SLOT_W-1:0]  i_raddr,
    output logic [tsom_pkg::OWNER_W-1:0] o_rdata
);
    import tsom_pkg::*;

    localparam int Depth = 1 << SLOT_W;

    logic [OWNER_W-1:0] r_mem [Depth];
    logic [OWNER_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tsom_walk.sv =====
// Tile-order scan walker: produces one slot index per advance, 256 at most.
module tsom_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsom_pkg::t_walk_ctl i_ctl,
    output tsom_pkg::t_walk_sts o_sts
);
    import tsom_pkg::*;

    logic [WALK_W-1:0] r_col;
    logic [WALK_W-1:0] r_row;
    logic [SLOT_W:0]   r_cnt;
    logic [WALK_W-1:0] n_col;
    logic [WALK_W-1:0] n_row;

    // One scan step; rows reaching 15 jump to 16, so row 15 is only seen at start.
    always_comb begin
        n_col = r_col + WALK_W'(1);
        n_row = r_row;
        if (n_col[1:0] == 2'b00) begin
            n_row = n_row + WALK_W'(1);
            if (n_row >= WALK_W'(15)) begin
                n_row = WALK_W'(16);
            end
            if (n_row[1:0] == 2'b00) begin
                n_row = n_row - WALK_W'(4);
            end else begin
                n_col = n_col - WALK_W'(4);
            end
            if (n_col >= WALK_W'(16)) begin
                n_row = n_row + WALK_W'(4);
                n_col = '0;
                if (n_row >= WALK_W'(16)) begin
                    n_row = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= {1'b1, {SLOT_W{1'b0}}};
        end else if (i_ctl.start) begin
            r_col <= {1'b0, i_ctl.col};
            r_row <= {1'b0, i_ctl.row};
            r_cnt <= '0;
        end else if (i_ctl.advance && !r_cnt[SLOT_W]) begin
            r_col <= n_col;
            r_row <= n_row;
            r_cnt <= r_cnt + (SLOT_W+1)'(1);
        end
    end

    assign o_sts.done = r_cnt[SLOT_W];
    assign o_sts.idx  = {r_row[POS_W-1:0], r_col[POS_W-1:0]};

endmodule

// ===== rtl/tiled_slot_occupancy_map.sv =====
// Top level of the tiled slot occupancy map: stream ports and the operation sequencer.
`include "tiled_slot_occupancy_map_defines.svh"

// A 256-slot byte map (16 by 16 grid, 0 = free, owner+1 = held) lives in one
// synchronous RAM with a registered read. Each input beat carries one operation
// and yields exactly one output beat. Mark, set cursor and unused codes go
// straight to the result; reset sweeps the RAM one slot per cycle; release
// reads and writes back one slot per cycle; find walks 4x4 tiles one slot per
// cycle from the cursor and stops at the first free slot or at the end of its
// walk. After i_rst_n the block runs the same clearing pass before it takes
// its first beat. The RAM port (one read and one write per cycle) sets these
// rates. A new beat is taken once the previous operation has finished, even
// while its result still waits in the output register.
module tiled_slot_occupancy_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [2:0] operation, [10:3] owner, [18:11] slot, [22:19] start_col,
    // [26:23] start_row, [31:27] zero
    input  logic [tsom_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] found, [8:1] free_slot, [15:9] zero
    output logic [tsom_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import tsom_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REL,
        S_FIND,
        S_RESULT
    } t_state;

    t_state              r_state;
    logic [SLOT_W:0]     r_cnt;        // clear / release slot counter
    logic                r_clr_res;    // clearing pass was requested by a beat
    logic                r_p_vld;      // read data of r_p_idx arrives this cycle
    logic [SLOT_W-1:0]   r_p_idx;
    logic [OWNER_W:0]    r_owner_p1;   // owner+1, kept 9 bits so owner 255 never matches
    logic [POS_W-1:0]    r_cur_col;
    logic [POS_W-1:0]    r_cur_row;
    logic                r_res_found;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_valid;
    logic                r_out_found;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                w_acc;
    t_op                 w_op;
    logic [OWNER_W-1:0]  w_owner;
    logic [SLOT_W-1:0]   w_slot;
    logic [POS_W-1:0]    w_scol;
    logic [POS_W-1:0]    w_srow;
    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr;
    logic [OWNER_W-1:0]  w_wdata;
    logic [SLOT_W-1:0]   w_raddr;
    logic [OWNER_W-1:0]  w_rdata;
    logic                w_hit;
    logic                w_out_load;
    t_walk_ctl           w_walk_ctl;
    t_walk_sts           w_walk_sts;

    // Unpack the input beat.
    assign w_op    = t_op'(i_s_tdata[2:0]);
    assign w_owner = i_s_tdata[10:3];
    assign w_slot  = i_s_tdata[18:11];
    assign w_scol  = i_s_tdata[22:19];
    assign w_srow  = i_s_tdata[26:23];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Find hit: the slot read last cycle is free.
    assign w_hit = r_p_vld && (w_rdata == '0);

    // Move a finished result into the output register once it is free.
    assign w_out_load = (r_state == S_RESULT) && (!r_out_valid || i_m_tready);

    // Walker: load the cursor on a find beat, step while scanning.
    assign w_walk_ctl.start   = w_acc && (w_op == OP_FIND);
    assign w_walk_ctl.advance = (r_state == S_FIND) && !w_walk_sts.done;
    assign w_walk_ctl.col     = r_cur_col;
    assign w_walk_ctl.row     = r_cur_row;

    // RAM write port: clearing sweep, release write-back, or mark.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[SLOT_W-1:0];
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (r_state == S_REL && r_p_vld && ({1'b0, w_rdata} == r_owner_p1)) begin
            w_we    = 1'b1;
            w_waddr = r_p_idx;
        end else if (w_acc && w_op == OP_MARK) begin
            w_we    = 1'b1;
            w_waddr = w_slot;
            w_wdata = w_owner + OWNER_W'(1);
        end
    end

    // Release walks the map in index order; find follows the tile walker.
    assign w_raddr = (r_state == S_REL) ? r_cnt[SLOT_W-1:0] : w_walk_sts.idx;

    tsom_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tsom_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_walk_ctl),
        .o_sts   (w_walk_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_res   <= 1'b0;
            r_p_vld     <= 1'b0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_res_found <= 1'b0;
            r_res_slot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished result, or drop the output beat once taken.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + (SLOT_W+1)'(1);
                    if (r_cnt[SLOT_W-1:0] == '1) begin
                        r_state   <= r_clr_res ? S_RESULT : S_IDLE;
                        r_clr_res <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_res_found <= 1'b0;
                        r_res_slot  <= '0;
                        r_p_vld     <= 1'b0;
                        case (w_op)
                            OP_RESET: begin
                                r_cur_col <= '0;
                                r_cur_row <= '0;
                                r_cnt     <= '0;
                                r_clr_res <= 1'b1;
                                r_state   <= S_CLEAR;
                            end
                            OP_RELEASE: begin
                                r_owner_p1 <= {1'b0, w_owner} + (OWNER_W+1)'(1);
                                r_cnt      <= '0;
                                r_state    <= S_REL;
                            end
                            OP_FIND: begin
                                r_state <= S_FIND;
                            end
                            OP_CURSOR: begin
                                r_cur_col <= w_scol;
                                r_cur_row <= w_srow;
                                r_state   <= S_RESULT;
                            end
                            default: begin
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_REL: begin
                    // Read slot r_cnt, compare and write it back in the next cycle.
                    r_p_vld <= !r_cnt[SLOT_W];
                    r_p_idx <= r_cnt[SLOT_W-1:0];
                    if (!r_cnt[SLOT_W]) begin
                        r_cnt <= r_cnt + (SLOT_W+1)'(1);
                    end
                    if (r_cnt[SLOT_W] && r_p_vld) begin
                        r_state <= S_RESULT;
                    end
                end
                S_FIND: begin
                    r_p_idx <= w_walk_sts.idx;
                    if (w_hit) begin
                        r_res_found <= 1'b1;
                        r_res_slot  <= r_p_idx;
                        r_p_vld     <= 1'b0;
                        r_state     <= S_RESULT;
                    end else if (w_walk_sts.done && r_p_vld) begin
                        // Last of 256 walker positions checked, none free.
                        r_p_vld <= 1'b0;
                        r_state <= S_RESULT;
                    end else begin
                        r_p_vld <= !w_walk_sts.done;
                    end
                end
                S_RESULT: begin
                    // Hold until the output register is free.
                    if (w_out_load) begin
                        r_out_found <= r_res_found;
                        r_out_slot  <= r_res_slot;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W-SLOT_W-1)'(0), r_out_slot, r_out_found};

    // A free slot seen during a find is reported as found next cycle.
    `TSOM_ASSERT_NEXT(a_find_hit, i_clk, i_rst_n,
        (r_state == S_FIND) && w_hit, (r_state == S_RESULT) && r_res_found)

    // While idle, only a mark beat may write the map.
    `TSOM_ASSERT_NOW(a_idle_write, i_clk, i_rst_n,
        (r_state == S_IDLE) && w_we, w_acc && (w_op == OP_MARK))

    // A result leaving the sequencer always lands in the output register.
    `TSOM_ASSERT_NEXT(a_result_load, i_clk, i_rst_n,
        (r_state == S_RESULT) && (!r_out_valid || i_m_tready),
        r_out_valid && (r_state == S_IDLE))

endmodule
